FILE: hw/rtl/frp_pkg.sv
package frp_pkg;

	// Width of the halfmove and fullmove accumulators.
	localparam int unsigned COUNTER_BITS = 16;
	localparam logic [COUNTER_BITS-1:0] ACC_MAX = '1;

	localparam int unsigned HM_W  = 16;
	localparam int unsigned PLY_W = 17;
	localparam logic [32:0] HM_LIMIT  = 33'd65535;
	localparam logic [33:0] PLY_LIMIT = 34'd131071;

	// Command queue between the parser and the result generator.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_W     = 8'h77;

	// Result kinds
	localparam logic [1:0] RK_WRITE   = 2'd0;
	localparam logic [1:0] RK_SUMMARY = 2'd1;
	localparam logic [1:0] RK_ERROR   = 2'd2;

	// Piece sides
	localparam logic [1:0] SIDE_WHITE = 2'd0;
	localparam logic [1:0] SIDE_BLACK = 2'd1;
	localparam logic [1:0] SIDE_EMPTY = 2'd2;

	localparam logic [2:0] PK_EMPTY  = 3'd0;
	localparam logic [2:0] PK_PAWN   = 3'd1;
	localparam logic [2:0] PK_KNIGHT = 3'd2;
	localparam logic [2:0] PK_BISHOP = 3'd3;
	localparam logic [2:0] PK_ROOK   = 3'd4;
	localparam logic [2:0] PK_QUEEN  = 3'd5;
	localparam logic [2:0] PK_KING   = 3'd6;

	// Error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_PIECE     = 4'd1;
	localparam logic [3:0] ERR_RANK      = 4'd2;
	localparam logic [3:0] ERR_SEPARATOR = 4'd3;
	localparam logic [3:0] ERR_SPACE     = 4'd4;
	localparam logic [3:0] ERR_COLOR     = 4'd5;
	localparam logic [3:0] ERR_CASTLING  = 4'd6;
	localparam logic [3:0] ERR_EP_FILE   = 4'd7;
	localparam logic [3:0] ERR_EP_RANK   = 4'd8;
	localparam logic [3:0] ERR_HALFMOVE  = 4'd9;
	localparam logic [3:0] ERR_FULLMOVE  = 4'd10;
	localparam logic [3:0] ERR_TRAILING  = 4'd11;

	typedef enum logic [3:0] {
		PH_PLACE,
		PH_SLASH,
		PH_SPACE_A,
		PH_COLOR,
		PH_SPACE_B,
		PH_CASTLE_FIRST,
		PH_CASTLE_MORE,
		PH_CASTLE_DASH,
		PH_EP_FILE,
		PH_EP_RANK,
		PH_SPACE_C,
		PH_HALF,
		PH_FULL,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] side;
	} piece_t;

	// One command: a run of square writes, a summary or an error.
	typedef struct packed {
		logic [1:0]       kind;
		logic [5:0]       square;
		logic [2:0]       count_m1;
		logic [2:0]       piece_kind;
		logic [1:0]       piece_side;
		logic             black_to_move;
		logic [3:0]       castling;
		logic             passant_valid;
		logic [5:0]       passant_square;
		logic [HM_W-1:0]  halfmove;
		logic [PLY_W-1:0] ply;
		logic [3:0]       error_code;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [5:0]       square;
		logic [2:0]       piece_kind;
		logic [1:0]       piece_side;
		logic             black_to_move;
		logic [3:0]       castling;
		logic             passant_valid;
		logic [5:0]       passant_square;
		logic [HM_W-1:0]  halfmove;
		logic [PLY_W-1:0] ply;
		logic [3:0]       error_code;
	} res_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	function automatic piece_t piece_of(input logic [7:0] c);
		logic [7:0] low;
		piece_t     p;
		low = c | 8'h20;
		p.side = (c == low) ? SIDE_BLACK : SIDE_WHITE;
		case (low)
			8'h70:   p.kind = PK_PAWN;
			8'h6E:   p.kind = PK_KNIGHT;
			8'h62:   p.kind = PK_BISHOP;
			8'h72:   p.kind = PK_ROOK;
			8'h71:   p.kind = PK_QUEEN;
			8'h6B:   p.kind = PK_KING;
			default: p.kind = PK_EMPTY;
		endcase
		return p;
	endfunction

	function automatic logic [3:0] castle_bit(input logic [7:0] c);
		logic [3:0] b;
		case (c)
			8'h4B:   b = 4'b0001;
			8'h51:   b = 4'b0010;
			8'h6B:   b = 4'b0100;
			8'h71:   b = 4'b1000;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

	// Decimal accumulate with saturation at the counter limit.
	function automatic logic [COUNTER_BITS-1:0] acc_digit(
		input logic [COUNTER_BITS-1:0] acc,
		input logic [3:0]              d
	);
		logic [COUNTER_BITS+3:0] w;
		w = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + (COUNTER_BITS+4)'(d);
		return (w > (COUNTER_BITS+4)'(ACC_MAX)) ? ACC_MAX : w[COUNTER_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/frp_front.sv
module frp_front
	import frp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       end_of_record,
	output logic       push,
	output cmd_t       cmd
);

	phase_t                  phase_q, phase_d;
	logic [2:0]              rank_q, rank_d;
	logic [2:0]              file_q, file_d;
	logic                    side_q, side_d;
	logic [3:0]              castle_q, castle_d;
	logic [2:0]              ep_file_q, ep_file_d;
	logic                    ep_present_q, ep_present_d;
	logic [5:0]              ep_index_q, ep_index_d;
	logic [COUNTER_BITS-1:0] hm_q, hm_d;
	logic [COUNTER_BITS-1:0] fm_q, fm_d;
	logic                    seen_q, seen_d;
	logic                    skip_q, skip_d;

	logic       is_digit, is_d18, is_file;
	piece_t     pc;
	logic [3:0] cb;
	logic [3:0] file_sum;
	logic [3:0] err_c, end_c;
	logic [32:0] hm_ext;
	logic [33:0] ply_ext;

	assign is_digit = text_byte inside {[CH_0:CH_9]};
	assign is_d18   = text_byte inside {[CH_1:CH_8]};
	assign is_file  = text_byte inside {[CH_A:CH_H]};
	assign pc       = piece_of(text_byte);
	assign cb       = castle_bit(text_byte);
	assign file_sum = {1'b0, file_q} + (is_d18 ? text_byte[3:0] : 4'd1);

	// Classify the byte against the field that is expected.
	always_comb begin
		err_c = ERR_NONE;
		case (phase_q)
			PH_PLACE: begin
				if (is_d18) begin
					if (file_sum > 4'd8) err_c = ERR_RANK;
				end else if (pc.kind == PK_EMPTY) begin
					err_c = ERR_PIECE;
				end
			end
			PH_SLASH:        if (text_byte != CH_SLASH) err_c = ERR_SEPARATOR;
			PH_SPACE_A,
			PH_SPACE_B,
			PH_SPACE_C:      if (text_byte != CH_SPACE) err_c = ERR_SPACE;
			PH_COLOR:        if (text_byte != CH_W && text_byte != CH_B) err_c = ERR_COLOR;
			PH_CASTLE_FIRST: if (text_byte != CH_DASH && cb == 4'b0000) err_c = ERR_CASTLING;
			PH_CASTLE_MORE:  if (text_byte != CH_SPACE && cb == 4'b0000) err_c = ERR_CASTLING;
			PH_CASTLE_DASH:  if (text_byte != CH_SPACE) err_c = ERR_CASTLING;
			PH_EP_FILE:      if (text_byte != CH_DASH && !is_file) err_c = ERR_EP_FILE;
			PH_EP_RANK:      if (!is_d18) err_c = ERR_EP_RANK;
			PH_HALF: begin
				if (!is_digit) begin
					if (!seen_q) err_c = ERR_HALFMOVE;
					else if (text_byte != CH_SPACE) err_c = ERR_SPACE;
				end
			end
			PH_FULL: begin
				if (!is_digit) begin
					if (!seen_q || fm_q == '0) err_c = ERR_FULLMOVE;
					else if (text_byte != CH_NL) err_c = ERR_TRAILING;
				end
			end
			PH_TAIL:         err_c = ERR_TRAILING;
			default:         err_c = ERR_PIECE;
		endcase
	end

	// Outcome of an end marker in the current phase.
	always_comb begin
		case (phase_q)
			PH_PLACE:        end_c = ERR_PIECE;
			PH_SLASH:        end_c = ERR_SEPARATOR;
			PH_SPACE_A,
			PH_SPACE_B,
			PH_SPACE_C:      end_c = ERR_SPACE;
			PH_COLOR:        end_c = ERR_COLOR;
			PH_CASTLE_FIRST,
			PH_CASTLE_MORE,
			PH_CASTLE_DASH:  end_c = ERR_CASTLING;
			PH_EP_FILE:      end_c = ERR_EP_FILE;
			PH_EP_RANK:      end_c = ERR_EP_RANK;
			PH_HALF:         end_c = seen_q ? ERR_SPACE : ERR_HALFMOVE;
			PH_FULL:         end_c = (!seen_q || fm_q == '0) ? ERR_FULLMOVE : ERR_NONE;
			PH_TAIL:         end_c = ERR_NONE;
			default:         end_c = ERR_PIECE;
		endcase
	end

	// Next state
	always_comb begin
		phase_d      = phase_q;
		rank_d       = rank_q;
		file_d       = file_q;
		side_d       = side_q;
		castle_d     = castle_q;
		ep_file_d    = ep_file_q;
		ep_present_d = ep_present_q;
		ep_index_d   = ep_index_q;
		hm_d         = hm_q;
		fm_d         = fm_q;
		seen_d       = seen_q;
		skip_d       = skip_q;
		if (accept) begin
			if (end_of_record) begin
				phase_d      = PH_PLACE;
				rank_d       = '0;
				file_d       = '0;
				side_d       = 1'b0;
				castle_d     = '0;
				ep_file_d    = '0;
				ep_present_d = 1'b0;
				ep_index_d   = '0;
				hm_d         = '0;
				fm_d         = '0;
				seen_d       = 1'b0;
				skip_d       = 1'b0;
			end else if (!skip_q) begin
				if (err_c != ERR_NONE) begin
					skip_d = 1'b1;
				end else begin
					case (phase_q)
						PH_PLACE: begin
							if (file_sum >= 4'd8) begin
								file_d  = '0;
								phase_d = (rank_q == 3'd7) ? PH_SPACE_A : PH_SLASH;
							end else begin
								file_d = file_sum[2:0];
							end
						end
						PH_SLASH: begin
							rank_d  = rank_q + 3'd1;
							phase_d = PH_PLACE;
						end
						PH_SPACE_A: phase_d = PH_COLOR;
						PH_COLOR: begin
							side_d  = (text_byte == CH_B);
							phase_d = PH_SPACE_B;
						end
						PH_SPACE_B: phase_d = PH_CASTLE_FIRST;
						PH_CASTLE_FIRST: begin
							if (text_byte == CH_DASH) begin
								phase_d = PH_CASTLE_DASH;
							end else begin
								castle_d = castle_q | cb;
								phase_d  = PH_CASTLE_MORE;
							end
						end
						PH_CASTLE_MORE: begin
							if (text_byte == CH_SPACE) phase_d = PH_EP_FILE;
							else castle_d = castle_q | cb;
						end
						PH_CASTLE_DASH: phase_d = PH_EP_FILE;
						PH_EP_FILE: begin
							if (text_byte == CH_DASH) begin
								ep_present_d = 1'b0;
								phase_d      = PH_SPACE_C;
							end else begin
								ep_file_d = 3'(text_byte - CH_A);
								phase_d   = PH_EP_RANK;
							end
						end
						PH_EP_RANK: begin
							// Ranks are listed from the eighth down, so row = '8' - c.
							ep_index_d   = {3'(CH_8 - text_byte), ep_file_q};
							ep_present_d = 1'b1;
							phase_d      = PH_SPACE_C;
						end
						PH_SPACE_C: begin
							phase_d = PH_HALF;
							seen_d  = 1'b0;
						end
						PH_HALF: begin
							if (is_digit) begin
								hm_d   = acc_digit(hm_q, text_byte[3:0]);
								seen_d = 1'b1;
							end else begin
								phase_d = PH_FULL;
								seen_d  = 1'b0;
							end
						end
						PH_FULL: begin
							if (is_digit) begin
								fm_d   = acc_digit(fm_q, text_byte[3:0]);
								seen_d = 1'b1;
							end else begin
								phase_d = PH_TAIL;
							end
						end
						default: phase_d = phase_q;
					endcase
				end
			end
		end
	end

	assign hm_ext  = 33'(hm_q);
	assign ply_ext = ({1'b0, 33'(fm_q)} << 1) - (side_q ? 34'd1 : 34'd2);

	// Command to the result generator
	always_comb begin
		cmd  = '0;
		push = 1'b0;
		if (accept && !skip_q) begin
			if (end_of_record) begin
				push = 1'b1;
				if (end_c != ERR_NONE) begin
					cmd.kind       = RK_ERROR;
					cmd.error_code = end_c;
				end else begin
					cmd.kind           = RK_SUMMARY;
					cmd.black_to_move  = side_q;
					cmd.castling       = castle_q;
					cmd.passant_valid  = ep_present_q;
					cmd.passant_square = ep_present_q ? ep_index_q : 6'd0;
					cmd.halfmove       = (hm_ext > HM_LIMIT) ? '1 : hm_ext[HM_W-1:0];
					cmd.ply            = (ply_ext > PLY_LIMIT) ? '1 : ply_ext[PLY_W-1:0];
				end
			end else if (err_c != ERR_NONE) begin
				push           = 1'b1;
				cmd.kind       = RK_ERROR;
				cmd.error_code = err_c;
			end else if (phase_q == PH_PLACE) begin
				push       = 1'b1;
				cmd.kind   = RK_WRITE;
				cmd.square = {rank_q, file_q};
				if (is_d18) begin
					cmd.count_m1   = 3'(text_byte[3:0] - 4'd1);
					cmd.piece_kind = PK_EMPTY;
					cmd.piece_side = SIDE_EMPTY;
				end else begin
					cmd.piece_kind = pc.kind;
					cmd.piece_side = pc.side;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PLACE;
			rank_q       <= '0;
			file_q       <= '0;
			side_q       <= 1'b0;
			castle_q     <= '0;
			ep_file_q    <= '0;
			ep_present_q <= 1'b0;
			ep_index_q   <= '0;
			hm_q         <= '0;
			fm_q         <= '0;
			seen_q       <= 1'b0;
			skip_q       <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			rank_q       <= rank_d;
			file_q       <= file_d;
			side_q       <= side_d;
			castle_q     <= castle_d;
			ep_file_q    <= ep_file_d;
			ep_present_q <= ep_present_d;
			ep_index_q   <= ep_index_d;
			hm_q         <= hm_d;
			fm_q         <= fm_d;
			seen_q       <= seen_d;
			skip_q       <= skip_d;
		end
	end

endmodule

FILE: hw/rtl/frp_queue.sv
module frp_queue
	import frp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_data,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head           = slot_q[rd_ptr_q];
	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

FILE: hw/rtl/frp_back.sv
module frp_back
	import frp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head,
	input  q_stat_t stat,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res,
	output logic    res_last
);

	logic [2:0] offset_q;
	logic       valid_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       final_elem;
	res_t       next_res;

	assign load       = stat.not_empty && (!valid_q || res_ready);
	assign final_elem = (offset_q == head.count_m1);
	assign pop        = load && final_elem;

	always_comb begin
		next_res = '0;
		next_res.kind = head.kind;
		case (head.kind)
			RK_WRITE: begin
				next_res.square     = head.square + 6'(offset_q);
				next_res.piece_kind = head.piece_kind;
				next_res.piece_side = head.piece_side;
			end
			RK_SUMMARY: begin
				next_res.black_to_move  = head.black_to_move;
				next_res.castling       = head.castling;
				next_res.passant_valid  = head.passant_valid;
				next_res.passant_square = head.passant_square;
				next_res.halfmove       = head.halfmove;
				next_res.ply            = head.ply;
			end
			default: next_res.error_code = head.error_code;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			offset_q <= '0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				offset_q <= final_elem ? 3'd0 : offset_q + 3'd1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= next_res;
			last_q <= final_elem;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;
	assign res_last  = last_q;

endmodule

FILE: hw/rtl/fen_record_parser.sv
// The command for an input byte is registered in the command queue, and its result then in the
// output register. Throughput: one byte per cycle; a digit of n empty squares holds the result
// stage while it emits n square writes, and input stalls only once the four-entry command queue
// between parser and result generator fills.
// Reset (arst_n low) clears the parser state, the command queue and the output valid.
module fen_record_parser
	import frp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] end_of_record
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [5:0] square_index, [8:6] piece_kind, [10:9] piece_side,
	                               // [11] black_to_move, [15:12] castling_rights,
	                               // [16] passant_valid, [22:17] passant_square,
	                               // [38:23] halfmove_clock, [55:39] ply_count,
	                               // [59:56] error_code, [63:60] zero
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast
);

	logic    accept;
	logic    push;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    pop;
	res_t    res;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	frp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.text_byte     (s_tdata),
		.end_of_record (s_tuser),
		.push          (push),
		.cmd           (push_cmd)
	);

	frp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	frp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (q_stat),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res),
		.res_last  (m_tlast)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {4'b0000, res.error_code, res.ply, res.halfmove, res.passant_square,
		res.passant_valid, res.castling, res.black_to_move, res.piece_side,
		res.piece_kind, res.square};

	// Only a run of square writes produces results that are not the last of their byte.
	a_nonlast_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == RK_WRITE))
		else $error("non-final result is not a square write");

	// Within a run the next result follows at once on the next square.
	a_run_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))
		else $error("empty-square run did not advance");

	// Empty kind and empty side always go together on a square write.
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RK_WRITE) |->
		((m_tdata[8:6] == PK_EMPTY) == (m_tdata[10:9] == SIDE_EMPTY)))
		else $error("square write with inconsistent piece and side");

	// An error result always carries a code and is the last result of its byte.
	a_error_coded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RK_ERROR) |-> (m_tdata[59:56] != ERR_NONE && m_tlast))
		else $error("error result without a code");

endmodule
